// File: rtl/cds_pkg.sv
// Shared types, constants and helper functions for the calendar date stepper.
package cds_pkg;

  localparam int YEAR_W  = 14;
  localparam int CENT_W  = 8;
  localparam int REM_W   = 7;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int REQ_W   = 3;
  localparam int WDAY_W  = 3;
  localparam int STAT_W  = 3;
  localparam int SUM_W   = 16;

  localparam int MAX_YEAR_DEF = 9999;
  localparam int RESET_YEAR   = 2000;

  // y / 100 == (y * DIV100_MUL) >> DIV100_SHIFT for every 14-bit y
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int PROD_W       = YEAR_W + 13;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD       = 3'd0,
    REQ_NEXT_DAY   = 3'd1,
    REQ_PREV_DAY   = 3'd2,
    REQ_NEXT_MONTH = 3'd3,
    REQ_PREV_MONTH = 3'd4,
    REQ_NEXT_YEAR  = 3'd5,
    REQ_PREV_YEAR  = 3'd6
  } req_kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_MONTH = 3'd1,
    ST_BAD_DAY   = 3'd2,
    ST_BAD_YEAR  = 3'd3,
    ST_LIMIT     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    YS_CUR  = 2'd0,
    YS_INC  = 2'd1,
    YS_DEC  = 2'd2,
    YS_LOAD = 2'd3
  } year_sel_t;

  typedef struct packed {
    logic [CENT_W-1:0] cent;
    logic [REM_W-1:0]  rem;
  } ysplit_t;

  // year is kept together with its century and year-in-century
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [CENT_W-1:0]  cent;
    logic [REM_W-1:0]   rem;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  function automatic logic is_leap(input logic [CENT_W-1:0] cent,
                                   input logic [REM_W-1:0] rem);
    is_leap = (rem[1:0] == 2'd0) && ((rem != '0) || (cent[1:0] == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    case (month)
      4'd2:                      month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
      default:                   month_len = 5'd31;
    endcase
  endfunction

  function automatic logic [2:0] wk_offset(input logic [MONTH_W-1:0] month);
    case (month)
      4'd1:    wk_offset = 3'd0;
      4'd2:    wk_offset = 3'd3;
      4'd3:    wk_offset = 3'd2;
      4'd4:    wk_offset = 3'd5;
      4'd5:    wk_offset = 3'd0;
      4'd6:    wk_offset = 3'd3;
      4'd7:    wk_offset = 3'd5;
      4'd8:    wk_offset = 3'd1;
      4'd9:    wk_offset = 3'd4;
      4'd10:   wk_offset = 3'd6;
      4'd11:   wk_offset = 3'd2;
      default: wk_offset = 3'd4;
    endcase
  endfunction

  function automatic ysplit_t split_year(input logic [YEAR_W-1:0] year);
    logic [PROD_W-1:0] prod;
    logic [CENT_W-1:0] q;
    logic [YEAR_W-1:0] r;
    prod = PROD_W'(year) * PROD_W'(DIV100_MUL);
    q    = prod[DIV100_SHIFT +: CENT_W];
    r    = year - YEAR_W'(q) * YEAR_W'(100);
    split_year.cent = q;
    split_year.rem  = r[REM_W-1:0];
  endfunction

  function automatic ysplit_t split_inc(input ysplit_t s);
    if (s.rem == REM_W'(99)) begin
      split_inc.cent = s.cent + 1'b1;
      split_inc.rem  = '0;
    end else begin
      split_inc.cent = s.cent;
      split_inc.rem  = s.rem + 1'b1;
    end
  endfunction

  function automatic ysplit_t split_dec(input ysplit_t s);
    if (s.rem == '0) begin
      split_dec.cent = s.cent - 1'b1;
      split_dec.rem  = REM_W'(99);
    end else begin
      split_dec.cent = s.cent;
      split_dec.rem  = s.rem - 1'b1;
    end
  endfunction

  // 8 == 1 mod 7, so octal digits fold
  function automatic logic [2:0] mod7(input logic [SUM_W-1:0] v);
    logic [17:0] w;
    logic [5:0]  s1;
    logic [3:0]  s2;
    logic [3:0]  s3;
    w  = 18'(v);
    s1 = 6'(w[2:0]) + 6'(w[5:3]) + 6'(w[8:6]) + 6'(w[11:9])
       + 6'(w[14:12]) + 6'(w[17:15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = 4'(s2[2:0]) + 4'(s2[3]);
    if (s3 >= 4'd7) begin
      s3 = s3 - 4'd7;
    end
    mod7 = s3[2:0];
  endfunction

endpackage

// File: rtl/cds_req_if.sv
// Request channel: valid/ready handshake with the load date and request type.
interface cds_req_if;
  logic                         valid;
  logic                         ready;
  logic [cds_pkg::REQ_W-1:0]    req_type;
  logic [cds_pkg::YEAR_W-1:0]   load_year;
  logic [cds_pkg::MONTH_W-1:0]  load_month;
  logic [cds_pkg::DAY_W-1:0]    load_day;

  modport source (output valid, req_type, load_year, load_month, load_day, input ready);
  modport sink   (input valid, req_type, load_year, load_month, load_day, output ready);
endinterface

// File: rtl/cds_res_if.sv
// Result channel: valid/ready handshake with the held date, weekday and status.
interface cds_res_if;
  logic                         valid;
  logic                         ready;
  logic [cds_pkg::YEAR_W-1:0]   cur_year;
  logic [cds_pkg::MONTH_W-1:0]  cur_month;
  logic [cds_pkg::DAY_W-1:0]    cur_day;
  logic [cds_pkg::WDAY_W-1:0]   weekday;
  logic [cds_pkg::STAT_W-1:0]   status;

  modport source (output valid, cur_year, cur_month, cur_day, weekday, status, input ready);
  modport sink   (input valid, cur_year, cur_month, cur_day, weekday, status, output ready);
endinterface

// File: rtl/cds_next_date.sv
// Next-date logic: load checks, day/month/year steps, range limits and clamping.
module cds_next_date #(
  parameter int MAX_YEAR = cds_pkg::MAX_YEAR_DEF
) (
  input  cds_pkg::date_t                held,
  input  logic [cds_pkg::REQ_W-1:0]     req_type,
  input  logic [cds_pkg::YEAR_W-1:0]    load_year,
  input  logic [cds_pkg::MONTH_W-1:0]   load_month,
  input  logic [cds_pkg::DAY_W-1:0]     load_day,
  output cds_pkg::date_t                nxt,
  output cds_pkg::status_t              status
);

  localparam logic [cds_pkg::YEAR_W-1:0] MAX_Y = cds_pkg::YEAR_W'(MAX_YEAR);

  cds_pkg::ysplit_t   cur_s;
  cds_pkg::ysplit_t   inc_s;
  cds_pkg::ysplit_t   dec_s;
  cds_pkg::ysplit_t   load_s;
  logic               leap_cur;
  logic               leap_inc;
  logic               leap_dec;
  logic               leap_load;
  logic               leap_sel;
  cds_pkg::year_sel_t ysel;
  logic [cds_pkg::MONTH_W-1:0] m;
  logic [cds_pkg::DAY_W-1:0]   d;
  logic [cds_pkg::DAY_W-1:0]   len_sel;
  logic [cds_pkg::YEAR_W-1:0]  y_sel;
  cds_pkg::ysplit_t            s_sel;

  assign cur_s.cent = held.cent;
  assign cur_s.rem  = held.rem;
  assign inc_s      = cds_pkg::split_inc(cur_s);
  assign dec_s      = cds_pkg::split_dec(cur_s);
  assign load_s     = cds_pkg::split_year(load_year);
  assign leap_cur   = cds_pkg::is_leap(cur_s.cent, cur_s.rem);
  assign leap_inc   = cds_pkg::is_leap(inc_s.cent, inc_s.rem);
  assign leap_dec   = cds_pkg::is_leap(dec_s.cent, dec_s.rem);
  assign leap_load  = cds_pkg::is_leap(load_s.cent, load_s.rem);

  always_comb begin
    status = cds_pkg::ST_OK;
    ysel   = cds_pkg::YS_CUR;
    m      = held.month;
    d      = held.day;
    case (req_type)
      cds_pkg::REQ_LOAD: begin
        if (load_month == '0 || load_month > 4'd12) begin
          status = cds_pkg::ST_BAD_MONTH;
        end else if (load_day == '0 ||
                     load_day > cds_pkg::month_len(load_month, leap_load)) begin
          status = cds_pkg::ST_BAD_DAY;
        end else if (load_year == '0 || load_year > MAX_Y) begin
          status = cds_pkg::ST_BAD_YEAR;
        end else begin
          ysel = cds_pkg::YS_LOAD;
          m    = load_month;
          d    = load_day;
        end
      end
      cds_pkg::REQ_NEXT_DAY: begin
        if (held.day < cds_pkg::month_len(held.month, leap_cur)) begin
          d = held.day + 1'b1;
        end else if (held.month < 4'd12) begin
          m = held.month + 1'b1;
          d = 5'd1;
        end else if (held.year < MAX_Y) begin
          ysel = cds_pkg::YS_INC;
          m    = 4'd1;
          d    = 5'd1;
        end else begin
          status = cds_pkg::ST_LIMIT;
        end
      end
      cds_pkg::REQ_PREV_DAY: begin
        if (held.day > 5'd1) begin
          d = held.day - 1'b1;
        end else if (held.month > 4'd1) begin
          m = held.month - 1'b1;
          d = cds_pkg::month_len(held.month - 1'b1, leap_cur);
        end else if (held.year > 14'd1) begin
          ysel = cds_pkg::YS_DEC;
          m    = 4'd12;
          d    = 5'd31;
        end else begin
          status = cds_pkg::ST_LIMIT;
        end
      end
      cds_pkg::REQ_NEXT_MONTH: begin
        if (held.month < 4'd12) begin
          m = held.month + 1'b1;
        end else if (held.year < MAX_Y) begin
          ysel = cds_pkg::YS_INC;
          m    = 4'd1;
        end else begin
          status = cds_pkg::ST_LIMIT;
        end
      end
      cds_pkg::REQ_PREV_MONTH: begin
        if (held.month > 4'd1) begin
          m = held.month - 1'b1;
        end else if (held.year > 14'd1) begin
          ysel = cds_pkg::YS_DEC;
          m    = 4'd12;
        end else begin
          status = cds_pkg::ST_LIMIT;
        end
      end
      cds_pkg::REQ_NEXT_YEAR: begin
        if (held.year < MAX_Y) begin
          ysel = cds_pkg::YS_INC;
        end else begin
          status = cds_pkg::ST_LIMIT;
        end
      end
      cds_pkg::REQ_PREV_YEAR: begin
        if (held.year > 14'd1) begin
          ysel = cds_pkg::YS_DEC;
        end else begin
          status = cds_pkg::ST_LIMIT;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (ysel)
      cds_pkg::YS_INC: begin
        y_sel    = held.year + 1'b1;
        s_sel    = inc_s;
        leap_sel = leap_inc;
      end
      cds_pkg::YS_DEC: begin
        y_sel    = held.year - 1'b1;
        s_sel    = dec_s;
        leap_sel = leap_dec;
      end
      cds_pkg::YS_LOAD: begin
        y_sel    = load_year;
        s_sel    = load_s;
        leap_sel = leap_load;
      end
      default: begin
        y_sel    = held.year;
        s_sel    = cur_s;
        leap_sel = leap_cur;
      end
    endcase
    len_sel = cds_pkg::month_len(m, leap_sel);
    if (status == cds_pkg::ST_OK) begin
      nxt.year  = y_sel;
      nxt.cent  = s_sel.cent;
      nxt.rem   = s_sel.rem;
      nxt.month = m;
      nxt.day   = (d > len_sel) ? len_sel : d;
    end else begin
      nxt = held;
    end
  end

endmodule

// File: rtl/cds_weekday.sv
// Weekday of a date by Sakamoto's method, using the stored century split.
module cds_weekday (
  input  cds_pkg::date_t              date,
  output logic [cds_pkg::WDAY_W-1:0]  weekday
);

  cds_pkg::ysplit_t               s;
  cds_pkg::ysplit_t               s_dec;
  cds_pkg::ysplit_t               s_use;
  logic [cds_pkg::YEAR_W-1:0]     yy;
  logic [cds_pkg::SUM_W-1:0]      sum;
  logic                           early;

  assign s.cent = date.cent;
  assign s.rem  = date.rem;
  assign s_dec  = cds_pkg::split_dec(s);
  assign early  = (date.month < 4'd3) && (date.year != '0);
  assign yy     = early ? date.year - 1'b1 : date.year;
  assign s_use  = early ? s_dec : s;

  // minus the century is plus six times it, mod 7
  assign sum = cds_pkg::SUM_W'(yy)
             + cds_pkg::SUM_W'(yy >> 2)
             + cds_pkg::SUM_W'(s_use.cent) * cds_pkg::SUM_W'(6)
             + cds_pkg::SUM_W'(s_use.cent >> 2)
             + cds_pkg::SUM_W'(cds_pkg::wk_offset(date.month))
             + cds_pkg::SUM_W'(date.day);

  assign weekday = cds_pkg::mod7(sum);

endmodule

// File: rtl/calendar_date_stepper.sv
// Top level of the calendar date stepper: held date, result pipeline and checks.
// Holds one Gregorian date (reset 2000-01-01) and answers every request with one
// result carrying the held date, its weekday and a status. A request is taken every
// cycle while the result side is not stalled: the held date is updated in the cycle
// the request is accepted, the weekday is formed in a second register stage, and
// throughput is one request per cycle. The year is kept alongside its century and
// year-in-century, so leap tests on stepping need no division; a load splits the
// year with one constant multiply.
module calendar_date_stepper #(
  parameter int MAX_YEAR = cds_pkg::MAX_YEAR_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cds_req_if.sink    req,
  cds_res_if.source  res
);

  cds_pkg::date_t    held;
  cds_pkg::date_t    held_next;
  cds_pkg::status_t  status_next;
  cds_pkg::status_t  a_status;
  logic              a_valid;
  logic              o_valid;
  logic              b_ready;
  logic              accept;
  logic [cds_pkg::WDAY_W-1:0]  wday;
  logic [cds_pkg::YEAR_W-1:0]  o_year;
  logic [cds_pkg::MONTH_W-1:0] o_month;
  logic [cds_pkg::DAY_W-1:0]   o_day;
  logic [cds_pkg::WDAY_W-1:0]  o_wday;
  cds_pkg::status_t            o_status;

  cds_next_date #(
    .MAX_YEAR (MAX_YEAR)
  ) u_next (
    .held       (held),
    .req_type   (req.req_type),
    .load_year  (req.load_year),
    .load_month (req.load_month),
    .load_day   (req.load_day),
    .nxt        (held_next),
    .status     (status_next)
  );

  cds_weekday u_wday (
    .date    (held),
    .weekday (wday)
  );

  assign b_ready   = !o_valid || res.ready;
  assign req.ready = !a_valid || b_ready;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.year  <= cds_pkg::YEAR_W'(cds_pkg::RESET_YEAR);
      held.cent  <= cds_pkg::CENT_W'(cds_pkg::RESET_YEAR / 100);
      held.rem   <= cds_pkg::REM_W'(cds_pkg::RESET_YEAR % 100);
      held.month <= 4'd1;
      held.day   <= 5'd1;
      a_valid    <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      if (accept) begin
        held    <= held_next;
        a_valid <= 1'b1;
      end else if (b_ready) begin
        a_valid <= 1'b0;
      end
      if (b_ready) begin
        o_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_status <= status_next;
    end
    if (a_valid && b_ready) begin
      o_year   <= held.year;
      o_month  <= held.month;
      o_day    <= held.day;
      o_wday   <= wday;
      o_status <= a_status;
    end
  end

  assign res.valid     = o_valid;
  assign res.cur_year  = o_year;
  assign res.cur_month = o_month;
  assign res.cur_day   = o_day;
  assign res.weekday   = o_wday;
  assign res.status    = o_status;

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (held.month >= 4'd1) && (held.month <= 4'd12))
    else $error("held month out of range");

  a_day_fits: assert property (@(posedge clk) disable iff (rst)
    (held.day >= 5'd1) &&
    (held.day <= cds_pkg::month_len(held.month, cds_pkg::is_leap(held.cent, held.rem))))
    else $error("held day outside month");

  a_split_match: assert property (@(posedge clk) disable iff (rst)
    held.year == cds_pkg::YEAR_W'(held.cent) * cds_pkg::YEAR_W'(100)
               + cds_pkg::YEAR_W'(held.rem))
    else $error("year split out of step with year");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && (status_next != cds_pkg::ST_OK)) |=> $stable(held))
    else $error("rejected request changed the held date");

endmodule
